// ===== rtl/sbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shifted binary tile packer package
// Image geometry, tile store sizing, register indexes and the shared
// request type passed from the pixel mapper to the top level.
// ----------------------------------------------------------------------------
package sbtp_pkg;

    localparam int IMAGE_WIDTH  = 28;
    localparam int IMAGE_HEIGHT = 28;
    localparam int TILE_SIDE    = 3;

    localparam int TILES_ACROSS = (IMAGE_WIDTH + TILE_SIDE - 1) / TILE_SIDE;
    localparam int TILES_DOWN   = (IMAGE_HEIGHT + TILE_SIDE - 1) / TILE_SIDE;
    localparam int TILE_COUNT   = TILES_ACROSS * TILES_DOWN;
    localparam int TILE_AW      = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

    localparam int WORD_W  = 9;
    localparam int PIX_W   = 8;
    localparam int SHIFT_W = 5;
    localparam int CNT_W   = 5;
    localparam int SEL_W   = 7;
    localparam int DST_W   = 7;
    localparam int BIT_W   = 5;
    localparam int IDX_W   = ((TILE_AW > SEL_W) ? TILE_AW : SEL_W) + 1;

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd64;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SHIFT_X   = 2'd1,
        CFG_SHIFT_Y   = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

    typedef struct packed {
        logic                hit;
        logic [TILE_AW-1:0]  addr;
        logic [WORD_W-1:0]   mask;
    } t_pix_req;

    function automatic logic [CNT_W-1:0] tile_quot(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] q;
        q = '0;
        for (int k = 1; k < (1 << CNT_W); k++) begin
            if ((k * TILE_SIDE) < (1 << CNT_W)) begin
                if (v >= CNT_W'(k * TILE_SIDE)) begin
                    q = q + CNT_W'(1);
                end
            end
        end
        return q;
    endfunction

endpackage

// ===== rtl/sbtp_tile_ram.sv =====
// ----------------------------------------------------------------------------
// Tile store
// One word per tile, registered synchronous read, one write
// port. Per-entry valid bits make unwritten tiles read as zero after reset.
// ----------------------------------------------------------------------------
module sbtp_tile_ram
    import sbtp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [TILE_AW-1:0] i_rd_addr,
    output logic [WORD_W-1:0]  o_rd_data,
    input  logic               i_wr_en,
    input  logic [TILE_AW-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]  i_wr_data
);

    logic [WORD_W-1:0] r_mem [TILE_COUNT];
    logic [TILE_COUNT-1:0] r_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/sbtp_pixel_map.sv =====
// ----------------------------------------------------------------------------
// Pixel mapper
// Raster row and column counters, shift, bounds check, threshold and the
// tile address and bit mask of the current source pixel.
// ----------------------------------------------------------------------------
module sbtp_pixel_map
    import sbtp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [PIX_W-1:0]   i_threshold,
    input  logic [SHIFT_W-1:0] i_shift_x,
    input  logic [SHIFT_W-1:0] i_shift_y,
    output t_pix_req           o_req
);

    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_col, n_col;
    logic signed [DST_W-1:0] drow, dcol;
    logic [CNT_W-1:0] ur, uc, qr, qc, rr, rc;
    logic [BIT_W-1:0] bit_idx;
    logic in_img;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_step) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col + CNT_W'(1);
        if (r_col == CNT_W'(IMAGE_WIDTH - 1)) begin
            n_col = '0;
            n_row = (r_row == CNT_W'(IMAGE_HEIGHT - 1)) ? '0 : r_row + CNT_W'(1);
        end
    end

    always_comb begin
        drow = $signed({{(DST_W - CNT_W){1'b0}}, r_row})
             - $signed({{(DST_W - SHIFT_W){i_shift_y[SHIFT_W-1]}}, i_shift_y});
        dcol = $signed({{(DST_W - CNT_W){1'b0}}, r_col})
             - $signed({{(DST_W - SHIFT_W){i_shift_x[SHIFT_W-1]}}, i_shift_x});
        in_img = !drow[DST_W-1] && !dcol[DST_W-1]
              && (drow < DST_W'(IMAGE_HEIGHT)) && (dcol < DST_W'(IMAGE_WIDTH));
        ur = drow[CNT_W-1:0];
        uc = dcol[CNT_W-1:0];
        qr = tile_quot(ur);
        qc = tile_quot(uc);
        rr = ur - CNT_W'(qr * CNT_W'(TILE_SIDE));
        rc = uc - CNT_W'(qc * CNT_W'(TILE_SIDE));
        bit_idx = BIT_W'(rc) + BIT_W'(rr * BIT_W'(TILE_SIDE));
        o_req.hit  = in_img && (i_pixel >= i_threshold) && (bit_idx < BIT_W'(WORD_W));
        o_req.addr = TILE_AW'(qc) + TILE_AW'(qr * TILE_AW'(TILES_ACROSS));
        o_req.mask = WORD_W'(1) << bit_idx;
    end

endmodule

// ===== rtl/shifted_binary_tile_packer_top.sv =====
// ----------------------------------------------------------------------------
// Shifted binary tile packer
// Maps raster pixels through a configured shift into thresholded 3x3 tile
// words held in a tile store; read items return and clear one tile word.
//
//   channel   valid          stall          payload
//   input     i_in_valid     o_in_stall     i_mode, i_pixel, i_tile_select
//   output    o_out_valid    i_out_stall    o_tile_bits, o_tile_number
//   config    i_cfg_we       -              i_cfg_index, i_cfg_data
//
// One item per cycle unless a waiting result is stalled: the tile store is
// read on transfer and written back from the b stage registers; a write
// forwarded to a read of the same tile covers the overlap. A read result
// passes through the b stage into the output register. Reset clears the
// counters, pipeline valid flags and tile valid bits and reloads the config
// registers. A stalled output with a waiting result freezes the whole pipeline.
// ----------------------------------------------------------------------------
module shifted_binary_tile_packer_top
    import sbtp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [SEL_W-1:0]   i_tile_select,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_tile_bits,
    output logic [SEL_W-1:0]   o_tile_number,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [PIX_W-1:0]   i_cfg_data
);

    logic [PIX_W-1:0]   r_threshold;
    logic [SHIFT_W-1:0] r_shift_x;
    logic [SHIFT_W-1:0] r_shift_y;

    logic               advance;
    logic               in_xfer;
    logic               pix_step;
    t_pix_req           pix_req;
    logic [IDX_W-1:0]   sel_idx;
    logic               sel_ok;
    logic               a_act;
    logic [TILE_AW-1:0] a_addr;

    logic               r_b_valid;
    logic               r_b_read;
    logic               r_b_act;
    logic [TILE_AW-1:0] r_b_addr;
    logic [WORD_W-1:0]  r_b_mask;
    logic [SEL_W-1:0]   r_b_sel;

    logic               r_fwd_v;
    logic [TILE_AW-1:0] r_fwd_addr;
    logic [WORD_W-1:0]  r_fwd_data;

    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  cur_word;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_tile_bits;
    logic [SEL_W-1:0]   r_tile_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_SHIFT_X:   r_shift_x   <= i_cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y:   r_shift_y   <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign in_xfer    = i_in_valid && advance;
    assign pix_step   = in_xfer && (t_mode'(i_mode) == MODE_PIXEL);

    sbtp_pixel_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (pix_step),
        .i_pixel     (i_pixel),
        .i_threshold (r_threshold),
        .i_shift_x   (r_shift_x),
        .i_shift_y   (r_shift_y),
        .o_req       (pix_req)
    );

    always_comb begin
        sel_idx = IDX_W'(i_tile_select);
        sel_ok  = sel_idx < IDX_W'(TILE_COUNT);
        if (t_mode'(i_mode) == MODE_READ) begin
            a_act  = sel_ok;
            a_addr = sel_idx[TILE_AW-1:0];
        end else begin
            a_act  = pix_req.hit;
            a_addr = pix_req.addr;
        end
    end

    sbtp_tile_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer && a_act),
        .i_rd_addr (a_addr),
        .o_rd_data (ram_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_b_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        cur_word = (r_fwd_v && (r_fwd_addr == r_b_addr)) ? r_fwd_data : ram_q;
        wr_en    = advance && r_b_valid && r_b_act;
        wr_data  = r_b_read ? '0 : (cur_word | r_b_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid   <= in_xfer;
            r_fwd_v     <= wr_en;
            r_out_valid <= r_b_valid && r_b_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_read      <= (t_mode'(i_mode) == MODE_READ);
            r_b_act       <= a_act;
            r_b_addr      <= a_addr;
            r_b_mask      <= pix_req.mask;
            r_b_sel       <= i_tile_select;
            r_fwd_addr    <= r_b_addr;
            r_fwd_data    <= wr_data;
            r_tile_bits   <= r_b_act ? cur_word : '0;
            r_tile_number <= r_b_sel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tile_bits   = r_tile_bits;
    assign o_tile_number = r_tile_number;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Shifted binary tile packer testbench
// Streams raster pixels and tile reads through the valid/stall input channel,
// tracks the shifted, thresholded tile store in a scoreboard, and compares
// every tile word read back. Covers register extremes between phases, random
// idling on both channels, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbtp_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [WORD_W-1:0] bits;
        logic [SEL_W-1:0]  number;
    } tile_read_t;

    class tile_packer_board;
        logic [WORD_W-1:0] store [TILE_COUNT];
        tile_read_t        reads_due [$];
        logic [PIX_W-1:0]  level;
        int                row;
        int                col;
        int                dx;
        int                dy;
        int                faults;

        function new();
            foreach (store[i]) store[i] = '0;
            level  = THRESHOLD_RST;
            row    = 0;
            col    = 0;
            dx     = 0;
            dy     = 0;
            faults = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [PIX_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: level = data;
                CFG_SHIFT_X:   dx = $signed(data[SHIFT_W-1:0]);
                CFG_SHIFT_Y:   dy = $signed(data[SHIFT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void take_item(t_mode mode, logic [PIX_W-1:0] pixel,
                                logic [SEL_W-1:0] sel);
            tile_read_t rd;
            int drow;
            int dcol;
            int tile;
            int bitn;
            if (mode == MODE_PIXEL) begin
                drow = row - dy;
                dcol = col - dx;
                col++;
                if (col >= IMAGE_WIDTH) begin
                    col = 0;
                    row++;
                    if (row >= IMAGE_HEIGHT) row = 0;
                end
                if (drow >= 0 && drow < IMAGE_HEIGHT && dcol >= 0 && dcol < IMAGE_WIDTH
                        && pixel >= level) begin
                    tile = dcol / TILE_SIDE + (drow / TILE_SIDE) * TILES_ACROSS;
                    bitn = dcol % TILE_SIDE + (drow % TILE_SIDE) * TILE_SIDE;
                    if (tile < TILE_COUNT && bitn < WORD_W) store[tile][bitn] = 1'b1;
                end
            end else begin
                rd.number = sel;
                rd.bits   = '0;
                if (sel < TILE_COUNT) begin
                    rd.bits    = store[sel];
                    store[sel] = '0;
                end
                reads_due.push_back(rd);
            end
        endfunction

        function void match_read(logic [WORD_W-1:0] bits, logic [SEL_W-1:0] number);
            tile_read_t rd;
            if (reads_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected tile read: bits %03h tile %0d", bits, number);
                return;
            end
            rd = reads_due.pop_front();
            if (bits !== rd.bits || number !== rd.number) begin
                faults++;
                if (faults <= 10)
                    $display("tile read mismatch: expected bits %03h tile %0d, got bits %03h tile %0d",
                             rd.bits, rd.number, bits, number);
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_mode        = 1'b0;
    logic [PIX_W-1:0]   i_pixel       = '0;
    logic [SEL_W-1:0]   i_tile_select = '0;
    logic               i_out_stall   = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_index   = '0;
    logic [PIX_W-1:0]   i_cfg_data    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [WORD_W-1:0]  o_tile_bits;
    logic [SEL_W-1:0]   o_tile_number;

    tile_packer_board board = new();
    bit quiet     = 1'b0;
    int hold_left = 0;
    int cycles    = 0;

    int thr_plan [PHASES] = '{0, 255, 37, 128, 0, 1};
    int sx_plan  [PHASES] = '{-8, 8, -16, 15, 0, 0};
    int sy_plan  [PHASES] = '{8, -8, 15, -16, 0, 1};

    shifted_binary_tile_packer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_pixel       (i_pixel),
        .i_tile_select (i_tile_select),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tile_bits   (o_tile_bits),
        .o_tile_number (o_tile_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hold the output for a long stretch when asked, else stall at random unless quiet
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.match_read(o_tile_bits, o_tile_number);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic send_item(t_mode mode, logic [PIX_W-1:0] pixel, logic [SEL_W-1:0] sel);
        int gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_pixel       <= pixel;
        i_tile_select <= sel;
        do @(posedge i_clk); while (o_in_stall);
        board.take_item(mode, pixel, sel);
        if (!quiet && $urandom_range(99) < 12) begin
            gap = $urandom_range(4, 1);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [PIX_W-1:0] pixel;
        logic [SEL_W-1:0] sel;
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            pixel = '0;
        else if (pick == 1)
            pixel = '1;
        else if (pick == 2)
            pixel = board.level + PIX_W'($urandom_range(2)) - PIX_W'(1);
        else
            pixel = PIX_W'($urandom);
        if ($urandom_range(7) == 0)
            sel = SEL_W'($urandom_range(127, TILE_COUNT));
        else
            sel = SEL_W'($urandom_range(TILE_COUNT - 1));
        send_item(($urandom_range(99) < 85) ? MODE_PIXEL : MODE_READ, pixel, sel);
    endtask

    task automatic load_reg(t_cfg_index idx, logic [PIX_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.reads_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int thr;
        int sx;
        int sy;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_PIXEL, 8'd64, 7'h55);
        send_item(MODE_PIXEL, 8'd63, 7'h2A);
        send_item(MODE_PIXEL, 8'd255, 7'h00);
        send_item(MODE_PIXEL, 8'd0, 7'h7F);
        send_item(MODE_READ, 8'hAA, 7'd0);
        send_item(MODE_READ, 8'h55, 7'd1);
        send_item(MODE_READ, 8'hFF, 7'd99);
        send_item(MODE_READ, 8'h00, 7'd100);
        send_item(MODE_READ, 8'h0F, 7'd127);
        send_item(MODE_READ, 8'hF0, 7'h55);
        send_item(MODE_READ, 8'h3C, 7'h2A);
        send_item(MODE_READ, 8'hC3, 7'd0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            thr = thr_plan[p];
            sx  = sx_plan[p];
            sy  = sy_plan[p];
            if (p == 4) begin
                thr = $urandom_range(255);
                sx  = int'($urandom_range(16)) - 8;
                sy  = int'($urandom_range(16)) - 8;
            end
            load_reg(CFG_THRESHOLD, PIX_W'(thr));
            load_reg(CFG_SHIFT_X, {3'($urandom), 5'(sx)});
            load_reg(CFG_SHIFT_Y, {3'($urandom), 5'(sy)});
            load_reg(CFG_UNUSED, PIX_W'($urandom));
            quiet = (p == 1);
            if (p == 0) hold_left = 400;
            repeat (PHASE_ITEMS) send_random();
            settle();
        end

        if (board.faults == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sbtp_pkg.sv
rtl/sbtp_tile_ram.sv
rtl/sbtp_pixel_map.sv
rtl/shifted_binary_tile_packer_top.sv
sim/tb.sv
